// ===== sv/aar_pkg.sv =====
// Shared types, constants and helper functions of the axis-angle rotation matrix block.
// No dependencies; the files that use it take what they need from here by scoped names.
`default_nettype none
package aar_pkg;

  // CORDIC stage count and arctangent table size
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned ATAN_ENTRIES      = 24;

  // Datapath widths
  localparam int unsigned CW = 34;   // CORDIC x, y, z (Q2.30 plus headroom)
  localparam int unsigned CS = 18;   // rounded cos / sin (Q2.14 plus headroom)

  // Angle reduction constants
  localparam logic [16:0] DEG_BIAS    = 17'd33120;    // 92 * 360, keeps the degree part positive
  localparam logic [15:0] INV360_Q24  = 16'd46604;    // ceil(2^24 / 360)
  localparam logic [8:0]  DEG360      = 9'd360;
  localparam logic [8:0]  DEG90       = 9'd90;
  localparam logic [8:0]  DEG180      = 9'd180;
  localparam logic [8:0]  DEG270      = 9'd270;
  localparam logic [24:0] PI180_Q30   = 25'd18740330;
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [18:0]   ONE_Q14 = 19'sd16384;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } axis_t;

  // Data that travels alongside the CORDIC
  typedef struct packed {
    quad_e quad;
    axis_t axis;
  } side_t;

  // atan(2^-i) in Q2.30, truncated
  function automatic logic [29:0] atan_q30(input int unsigned i);
    logic [29:0] r;
    case (i)
      0:  r = 30'd843314856;
      1:  r = 30'd497837829;
      2:  r = 30'd263043836;
      3:  r = 30'd133525158;
      4:  r = 30'd67021686;
      5:  r = 30'd33543515;
      6:  r = 30'd16775850;
      7:  r = 30'd8388437;
      8:  r = 30'd4194282;
      9:  r = 30'd2097149;
      10: r = 30'd1048575;
      11: r = 30'd524287;
      12: r = 30'd262143;
      13: r = 30'd131071;
      14: r = 30'd65535;
      15: r = 30'd32767;
      16: r = 30'd16383;
      17: r = 30'd8191;
      18: r = 30'd4095;
      19: r = 30'd2047;
      20: r = 30'd1023;
      21: r = 30'd511;
      22: r = 30'd255;
      23: r = 30'd127;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // Clamp a rounded element into Q2.14
  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    logic signed [15:0] r;
    if (v > 24'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -24'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/aar_if.sv =====
// Valid/ready channel interfaces for the input and result items.
// No dependencies.
`default_nettype none
interface aar_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle_deg;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;

  modport source (output valid, angle_deg, axis_x, axis_y, axis_z, input ready);
  modport sink   (input valid, angle_deg, axis_x, axis_y, axis_z, output ready);
endinterface

interface aar_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] m00;
  logic signed [15:0] m01;
  logic signed [15:0] m02;
  logic signed [15:0] m10;
  logic signed [15:0] m11;
  logic signed [15:0] m12;
  logic signed [15:0] m20;
  logic signed [15:0] m21;
  logic signed [15:0] m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface
`default_nettype wire

// ===== sv/aar_reduce.sv =====
// Angle front end: modulo 360, quadrant split and degree-to-radian conversion, five stages.
// Depends on aar_pkg.
`default_nettype none
module aar_reduce (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           valid_i,
  input  wire logic signed [31:0]             angle_i,
  input  wire aar_pkg::axis_t                 axis_i,
  output logic                                valid_o,
  output logic signed [aar_pkg::CW-1:0]       z_o,
  output aar_pkg::side_t                      side_o
);

  logic [4:0] v_q;

  // stage 1: bias the integer degrees positive
  logic [16:0]    hiu1_q;
  logic [15:0]    lo1_q;
  aar_pkg::axis_t ax1_q;
  // stage 2: quotient by 360
  logic [16:0]    hiu2_q;
  logic [7:0]     q2_q;
  logic [15:0]    lo2_q;
  aar_pkg::axis_t ax2_q;
  // stage 3: quadrant and remainder in degrees
  logic [22:0]    rem3_q;
  aar_pkg::side_t sd3_q;
  // stage 4: radian partial products
  logic [40:0]    pl4_q;
  logic [31:0]    ph4_q;
  aar_pkg::side_t sd4_q;
  // stage 5: radians in Q2.30
  logic [31:0]    cz5_q;
  aar_pkg::side_t sd5_q;

  logic [16:0] hiu1_d;
  logic [32:0] qprod;
  logic [16:0] qx360;
  logic [8:0]  r3;
  logic [8:0]  rd3;
  aar_pkg::quad_e quad3;
  logic [48:0] czsum;

  assign hiu1_d = 17'(angle_i[31:16]) + aar_pkg::DEG_BIAS
                  - (angle_i[31] ? 17'h10000 : 17'd0);
  assign qprod  = 33'(hiu1_q) * 33'(aar_pkg::INV360_Q24);
  assign qx360  = 17'(q2_q) * 17'(aar_pkg::DEG360);
  assign r3     = 9'(hiu2_q - qx360);

  // Pick the quadrant and strip it from the degrees
  always_comb begin
    if (r3 < aar_pkg::DEG90) begin
      quad3 = aar_pkg::QUAD_0;
      rd3   = r3;
    end else if (r3 < aar_pkg::DEG180) begin
      quad3 = aar_pkg::QUAD_1;
      rd3   = r3 - aar_pkg::DEG90;
    end else if (r3 < aar_pkg::DEG270) begin
      quad3 = aar_pkg::QUAD_2;
      rd3   = r3 - aar_pkg::DEG180;
    end else begin
      quad3 = aar_pkg::QUAD_3;
      rd3   = r3 - aar_pkg::DEG270;
    end
  end

  assign czsum = {1'b0, ph4_q, 16'd0} + 49'(pl4_q) + 49'd32768;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hiu1_q    <= hiu1_d;
      lo1_q     <= angle_i[15:0];
      ax1_q     <= axis_i;
      hiu2_q    <= hiu1_q;
      q2_q      <= qprod[31:24];
      lo2_q     <= lo1_q;
      ax2_q     <= ax1_q;
      rem3_q    <= {rd3[6:0], lo2_q};
      sd3_q     <= '{quad: quad3, axis: ax2_q};
      pl4_q     <= 41'(rem3_q[15:0]) * 41'(aar_pkg::PI180_Q30);
      ph4_q     <= 32'(rem3_q[22:16]) * 32'(aar_pkg::PI180_Q30);
      sd4_q     <= sd3_q;
      cz5_q     <= czsum[47:16];
      sd5_q     <= sd4_q;
    end
  end

  assign valid_o = v_q[4];
  assign z_o     = {2'b00, cz5_q};
  assign side_o  = sd5_q;

endmodule
`default_nettype wire

// ===== sv/aar_cordic.sv =====
// Rotation-mode CORDIC, one register stage per iteration, carrying side data along.
// Depends on aar_pkg.
`default_nettype none
module aar_cordic #(
  parameter int unsigned STAGES = aar_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           valid_i,
  input  wire logic signed [aar_pkg::CW-1:0]  z_i,
  input  wire aar_pkg::side_t                 side_i,
  output logic                                valid_o,
  output logic signed [aar_pkg::CW-1:0]       x_o,
  output logic signed [aar_pkg::CW-1:0]       y_o,
  output aar_pkg::side_t                      side_o
);

  localparam int unsigned N  = (STAGES > aar_pkg::ATAN_ENTRIES) ? aar_pkg::ATAN_ENTRIES : STAGES;
  localparam int unsigned CW = aar_pkg::CW;

  logic signed [CW-1:0] x_w [N+1];
  logic signed [CW-1:0] y_w [N+1];
  logic signed [CW-1:0] z_w [N+1];
  aar_pkg::side_t       s_w [N+1];
  logic                 v_w [N+1];

  assign x_w[0] = aar_pkg::CORDIC_GAIN_Q30;
  assign y_w[0] = '0;
  assign z_w[0] = z_i;
  assign s_w[0] = side_i;
  assign v_w[0] = valid_i;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [CW-1:0] x_q, y_q, z_q;
    logic signed [CW-1:0] x_d, y_d, z_d;
    logic signed [CW-1:0] dx, dy, at;
    aar_pkg::side_t       s_q;
    logic                 v_q;

    // Rotate towards zero residual angle
    always_comb begin
      dx = y_w[i] >>> i;
      dy = x_w[i] >>> i;
      at = $signed({{(CW-30){1'b0}}, aar_pkg::atan_q30(i)});
      if (!z_w[i][CW-1]) begin
        x_d = x_w[i] - dx;
        y_d = y_w[i] + dy;
        z_d = z_w[i] - at;
      end else begin
        x_d = x_w[i] + dx;
        y_d = y_w[i] - dy;
        z_d = z_w[i] + at;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_w[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q <= x_d;
        y_q <= y_d;
        z_q <= z_d;
        s_q <= s_w[i];
      end
    end

    assign x_w[i+1] = x_q;
    assign y_w[i+1] = y_q;
    assign z_w[i+1] = z_q;
    assign s_w[i+1] = s_q;
    assign v_w[i+1] = v_q;
  end

  assign valid_o = v_w[N];
  assign x_o     = x_w[N];
  assign y_o     = y_w[N];
  assign side_o  = s_w[N];

endmodule
`default_nettype wire

// ===== sv/aar_matrix.sv =====
// Matrix back end: quadrant fix-up of cos/sin, axis products, element sums and saturation.
// Four stages, the last one is the output register. Depends on aar_pkg.
`default_nettype none
module aar_matrix (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           valid_i,
  input  wire logic signed [aar_pkg::CW-1:0]  x_i,
  input  wire logic signed [aar_pkg::CW-1:0]  y_i,
  input  wire aar_pkg::side_t                 side_i,
  output logic                                valid_o,
  output logic signed [15:0]                  m_o [9]
);

  localparam int unsigned CW = aar_pkg::CW;
  localparam int unsigned CS = aar_pkg::CS;

  logic [3:0] v_q;

  // stage 1
  logic signed [CS-1:0] c1_q, s1_q;
  aar_pkg::axis_t       ax1_q;
  // stage 2
  logic signed [18:0]   omc2_q;
  logic signed [CS-1:0] c2_q;
  logic signed [31:0]   pxx2_q, pxy2_q, pxz2_q, pyy2_q, pyz2_q, pzz2_q;
  logic signed [33:0]   xs2_q, ys2_q, zs2_q;
  // stage 3
  logic signed [CS-1:0] c3_q;
  logic signed [50:0]   txx3_q, txy3_q, txz3_q, tyy3_q, tyz3_q, tzz3_q;
  logic signed [33:0]   xs3_q, ys3_q, zs3_q;
  // stage 4 (output)
  logic signed [15:0]   m4_q [9];

  logic signed [CW-1:0] cq, sq;
  logic signed [CW:0]   cr, sr;
  logic signed [51:0]   ct, xx, xy, xz, yy, yz, zz, xs, ys, zs;
  logic signed [51:0]   e_d [9];

  // Map the first-quadrant result onto the real quadrant
  always_comb begin
    case (side_i.quad)
      aar_pkg::QUAD_1: begin cq = -y_i; sq =  x_i; end
      aar_pkg::QUAD_2: begin cq = -x_i; sq = -y_i; end
      aar_pkg::QUAD_3: begin cq =  y_i; sq = -x_i; end
      default:         begin cq =  x_i; sq =  y_i; end
    endcase
    cr = (CW+1)'(cq) + (CW+1)'(32768);
    sr = (CW+1)'(sq) + (CW+1)'(32768);
  end

  // Form the element sums in Q42
  always_comb begin
    ct = 52'(c3_q) <<< 28;
    xx = 52'(txx3_q);
    xy = 52'(txy3_q);
    xz = 52'(txz3_q);
    yy = 52'(tyy3_q);
    yz = 52'(tyz3_q);
    zz = 52'(tzz3_q);
    xs = 52'(xs3_q) <<< 14;
    ys = 52'(ys3_q) <<< 14;
    zs = 52'(zs3_q) <<< 14;
    e_d[0] = xx + ct;
    e_d[1] = xy + zs;
    e_d[2] = xz - ys;
    e_d[3] = xy - zs;
    e_d[4] = yy + ct;
    e_d[5] = yz + xs;
    e_d[6] = xz + ys;
    e_d[7] = yz - xs;
    e_d[8] = zz + ct;
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q   <= cr[CW-1:16];
      s1_q   <= sr[CW-1:16];
      ax1_q  <= side_i.axis;

      omc2_q <= aar_pkg::ONE_Q14 - 19'(c1_q);
      c2_q   <= c1_q;
      pxx2_q <= 32'(ax1_q.x) * 32'(ax1_q.x);
      pxy2_q <= 32'(ax1_q.x) * 32'(ax1_q.y);
      pxz2_q <= 32'(ax1_q.x) * 32'(ax1_q.z);
      pyy2_q <= 32'(ax1_q.y) * 32'(ax1_q.y);
      pyz2_q <= 32'(ax1_q.y) * 32'(ax1_q.z);
      pzz2_q <= 32'(ax1_q.z) * 32'(ax1_q.z);
      xs2_q  <= 34'(ax1_q.x) * 34'(s1_q);
      ys2_q  <= 34'(ax1_q.y) * 34'(s1_q);
      zs2_q  <= 34'(ax1_q.z) * 34'(s1_q);

      c3_q   <= c2_q;
      txx3_q <= 51'(pxx2_q) * 51'(omc2_q);
      txy3_q <= 51'(pxy2_q) * 51'(omc2_q);
      txz3_q <= 51'(pxz2_q) * 51'(omc2_q);
      tyy3_q <= 51'(pyy2_q) * 51'(omc2_q);
      tyz3_q <= 51'(pyz2_q) * 51'(omc2_q);
      tzz3_q <= 51'(pzz2_q) * 51'(omc2_q);
      xs3_q  <= xs2_q;
      ys3_q  <= ys2_q;
      zs3_q  <= zs2_q;

      for (int k = 0; k < 9; k++) begin
        m4_q[k] <= aar_pkg::sat16(24'((e_d[k] + 52'sd134217728) >>> 28));
      end
    end
  end

  assign valid_o = v_q[3];
  assign m_o     = m4_q;

endmodule
`default_nettype wire

// ===== sv/axis_angle_rotation_matrix.sv =====
// Top level of the axis-angle rotation matrix pipeline: angle front end, CORDIC, matrix back end.
// Depends on aar_pkg, aar_if, aar_reduce, aar_cordic and aar_matrix.
//
//   channel | dir | payload                              | handshake
//   in_i    | in  | angle_deg Q16.16, axis_x/y/z Q2.14    | valid/ready
//   out_o   | out | m00..m22 Q2.14, saturated            | valid/ready
//
// One item per cycle enters while the output is not stalled; the pipeline is made of the
// five front-end stages, one register per CORDIC iteration and four back-end stages.
// Reset clears only the valid bits and the in-flight count; payload registers are left as they are.
// The whole pipeline advances together whenever the output register is empty or being
// taken, so a stalled output holds every stage and nothing is lost or repeated.
`default_nettype none
module axis_angle_rotation_matrix #(
  parameter int unsigned CORDIC_STAGES = aar_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  aar_in_if.sink    in_i,
  aar_out_if.source out_o
);

  localparam int unsigned N     = (CORDIC_STAGES > aar_pkg::ATAN_ENTRIES)
                                  ? aar_pkg::ATAN_ENTRIES : CORDIC_STAGES;
  localparam int unsigned DEPTH = 9 + N;
  localparam int unsigned CNTW  = $clog2(DEPTH + 2);

  logic                        en;
  logic                        red_v, cor_v, mat_v;
  logic signed [aar_pkg::CW-1:0] red_z, cor_x, cor_y;
  aar_pkg::side_t              red_s, cor_s;
  aar_pkg::axis_t              axis_in;
  logic signed [15:0]          m [9];
  logic [CNTW-1:0]             cnt_q, cnt_d;

  // Advance while the output register is empty or being taken
  assign en         = !mat_v || out_o.ready;
  assign in_i.ready = en;
  assign axis_in    = '{x: in_i.axis_x, y: in_i.axis_y, z: in_i.axis_z};

  aar_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .angle_i (in_i.angle_deg),
    .axis_i  (axis_in),
    .valid_o (red_v),
    .z_o     (red_z),
    .side_o  (red_s)
  );

  aar_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (red_v),
    .z_i     (red_z),
    .side_i  (red_s),
    .valid_o (cor_v),
    .x_o     (cor_x),
    .y_o     (cor_y),
    .side_o  (cor_s)
  );

  aar_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cor_v),
    .x_i     (cor_x),
    .y_i     (cor_y),
    .side_i  (cor_s),
    .valid_o (mat_v),
    .m_o     (m)
  );

  assign out_o.valid = mat_v;
  assign out_o.m00   = m[0];
  assign out_o.m01   = m[1];
  assign out_o.m02   = m[2];
  assign out_o.m10   = m[3];
  assign out_o.m11   = m[4];
  assign out_o.m12   = m[5];
  assign out_o.m20   = m[6];
  assign out_o.m21   = m[7];
  assign out_o.m22   = m[8];

  // Track items in flight
  always_comb begin
    cnt_d = cnt_q;
    if (in_i.valid && in_i.ready) begin
      cnt_d = cnt_d + 1'b1;
    end
    if (out_o.valid && out_o.ready) begin
      cnt_d = cnt_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // No more items in flight than the pipeline has stages
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(DEPTH))
    else $error("more items in flight than pipeline stages");

  // A result only ever comes from an accepted item
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> cnt_q != '0)
    else $error("result presented with no item in flight");

  // A pipeline with nothing in flight that accepts no item presents no result
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 && !(in_i.valid && in_i.ready)) |=> !out_o.valid)
    else $error("result appeared from an empty pipeline");

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the axis-angle rotation matrix pipeline.
// Depends on aar_pkg, aar_if and axis_angle_rotation_matrix; drives and checks items by valid/ready.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  typedef struct {
    logic signed [31:0] angle;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    bit                 hold_off;  // wait for the pipeline to drain before sending
  } rot_req_t;

  typedef logic [8:0][15:0] matrix_t;

  localparam int unsigned STAGES    = aar_pkg::CORDIC_STAGES_DEF;
  localparam int unsigned LATENCY   = 9 + STAGES;
  localparam int          WDOG_MAX  = 5000;
  localparam int          N_RANDOM  = 1900;
  localparam longint      FULL_TURN = 64'sd23592960;
  localparam longint      QUARTER   = 64'sd5898240;
  localparam longint      RAD_SCALE = 64'sd18740330;
  localparam longint      GAIN      = 64'sd652032874;
  localparam longint      UNIT      = 64'sd16384;
  localparam longint      ATAN_TAB [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };
  localparam string ELEM_NAME [9] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                                      "m20", "m21", "m22"};

  logic clk_i;
  logic rst_ni;

  aar_in_if  in_bus ();
  aar_out_if out_bus ();

  axis_angle_rotation_matrix u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  rot_req_t pending_reqs[$];
  matrix_t  expected_mats[$];
  int       n_errors = 0;
  int       n_sent   = 0;
  int       idle_cnt = 0;
  bit       in_taken = 1'b0;

  // Round once, saturate to Q2.14
  function automatic logic [15:0] round_sat(longint sum);
    longint v;
    v = (sum + (64'sd1 <<< 27)) >>> 28;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Work out the rotation matrix for one angle and axis
  function automatic matrix_t rotation_matrix(rot_req_t r);
    longint  ang, ax, ay, az, md, quad, rem, cx, cy, cz, dx, dy, cq, sq, c, s, omc, ct;
    longint  xs, ys, zs, xx, xy, xz, yy, yz, zz;
    matrix_t m;
    ang = r.angle;
    ax  = r.x;
    ay  = r.y;
    az  = r.z;
    md = ang % FULL_TURN;
    if (md < 0) md += FULL_TURN;
    quad = md / QUARTER;
    rem  = md - quad * QUARTER;
    cz = (rem * RAD_SCALE + 64'sd32768) >>> 16;
    cx = GAIN;
    cy = 0;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cz >= 0) begin
        cx -= dx; cy += dy; cz -= ATAN_TAB[i];
      end else begin
        cx += dx; cy -= dy; cz += ATAN_TAB[i];
      end
    end
    case (quad)
      1: begin cq = -cy; sq = cx;  end
      2: begin cq = -cx; sq = -cy; end
      3: begin cq = cy;  sq = -cx; end
      default: begin cq = cx; sq = cy; end
    endcase
    c   = (cq + 64'sd32768) >>> 16;
    s   = (sq + 64'sd32768) >>> 16;
    omc = UNIT - c;
    ct  = c * (64'sd1 <<< 28);
    xs  = ax * s * UNIT;
    ys  = ay * s * UNIT;
    zs  = az * s * UNIT;
    xx  = ax * ax * omc;
    xy  = ax * ay * omc;
    xz  = ax * az * omc;
    yy  = ay * ay * omc;
    yz  = ay * az * omc;
    zz  = az * az * omc;
    m[0] = round_sat(xx + ct);
    m[1] = round_sat(xy + zs);
    m[2] = round_sat(xz - ys);
    m[3] = round_sat(xy - zs);
    m[4] = round_sat(yy + ct);
    m[5] = round_sat(yz + xs);
    m[6] = round_sat(xz + ys);
    m[7] = round_sat(yz - xs);
    m[8] = round_sat(zz + ct);
    return m;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic add_req(logic [31:0] a, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                         bit hold = 1'b0);
    rot_req_t r;
    r.angle = a; r.x = x; r.y = y; r.z = z; r.hold_off = hold;
    pending_reqs.push_back(r);
  endtask

  // Idle percentages per phase: receiver slow, then sender slow, then full rate
  function automatic int tx_idle_pct();
    return (n_sent < 650) ? 29 : (n_sent < 1300) ? 86 : 0;
  endfunction

  function automatic int rx_idle_pct();
    return (n_sent < 650) ? 86 : (n_sent < 1300) ? 29 : 0;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Drive input items at the falling edge
  always @(negedge clk_i) begin
    rot_req_t r;
    bit       busy;
    busy = in_bus.valid && !in_taken;
    if (rst_ni && !busy) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= tx_idle_pct()
          && (!pending_reqs[0].hold_off || expected_mats.size() == 0)) begin
        r = pending_reqs.pop_front();
        in_bus.angle_deg <= r.angle;
        in_bus.axis_x    <= r.x;
        in_bus.axis_y    <= r.y;
        in_bus.axis_z    <= r.z;
        in_bus.valid     <= 1'b1;
        n_sent++;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk_i) begin
    out_bus.ready <= rst_ni && ($urandom_range(99) >= rx_idle_pct());
  end

  // Sample both channels at the rising edge: predict, compare, watch for a hang
  always @(posedge clk_i) begin
    rot_req_t r;
    matrix_t  want;
    matrix_t  got;
    bit       in_fire;
    bit       out_fire;
    in_fire  = rst_ni && in_bus.valid && in_bus.ready;
    out_fire = rst_ni && out_bus.valid && out_bus.ready;
    in_taken <= in_fire;
    if (in_fire) begin
      r.angle = in_bus.angle_deg;
      r.x = in_bus.axis_x;
      r.y = in_bus.axis_y;
      r.z = in_bus.axis_z;
      r.hold_off = 1'b0;
      expected_mats.push_back(rotation_matrix(r));
    end
    if (out_fire) begin
      got = {out_bus.m22, out_bus.m21, out_bus.m20, out_bus.m12, out_bus.m11,
             out_bus.m10, out_bus.m02, out_bus.m01, out_bus.m00};
      if (expected_mats.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        want = expected_mats.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (got[i] !== want[i]) begin
            report_mismatch($sformatf("%s got %0d expected %0d", ELEM_NAME[i],
                                      $signed(got[i]), $signed(want[i])));
          end
        end
      end
    end
    // Count cycles with no handshake at all
    if (in_fire || out_fire || !rst_ni) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WDOG_MAX) begin
      $display("watchdog expired");
      $display("testbench failed");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // Stimulus and end of run
  initial begin
    in_bus.valid     = 1'b0;
    in_bus.angle_deg = '0;
    in_bus.axis_x    = '0;
    in_bus.axis_y    = '0;
    in_bus.axis_z    = '0;
    out_bus.ready    = 1'b0;
    rst_ni           = 1'b0;

    // Directed: quadrant edges, negative and extreme angles, extreme axes
    add_req(32'sd0,               16'sd16384, 16'sd0,      16'sd0);
    add_req(32'sd90 <<< 16,       16'sd0,     16'sd16384,  16'sd0);
    add_req(32'sd180 <<< 16,      16'sd0,     16'sd0,      16'sd16384);
    add_req(32'sd270 <<< 16,      16'sd9459,  16'sd9459,   16'sd9459);
    add_req(32'sd360 <<< 16,      16'sd16384, 16'sd0,      16'sd0);
    add_req(-(32'sd90 <<< 16),    16'sd0,     16'sd0,      16'sd16384);
    add_req(-(32'sd1),            16'sd16384, 16'sd16384,  16'sd0);
    add_req(32'sd45 <<< 16,       16'sd11585, 16'sd11585,  16'sd0);
    add_req(32'h7fffffff,         16'sh7fff,  16'sh7fff,   16'sh7fff);
    add_req(32'h80000000,         16'sh8000,  16'sh8000,   16'sh8000);
    add_req(32'h80000000,         16'sh7fff,  16'sh8000,   16'sh0000);
    add_req((32'sd90 <<< 16) - 1, 16'sh8000,  16'sh7fff,   16'sh7fff);
    add_req(32'sd1,               16'sh7fff,  16'sh8000,   16'sh7fff);
    add_req(32'sd135 <<< 16,      16'sh0000,  16'sh0000,   16'sh0000);
    add_req(32'sd225 <<< 16,      16'shffff,  16'sh0001,   16'sh8000);
    add_req(32'sd719 <<< 16,      16'sd16384, 16'sh8000,   16'sd100);
    add_req(32'hffff8000,         16'sd5000,  -16'sd5000,  16'sd14000);
    add_req(32'sd60 <<< 16,       16'sh7fff,  16'sh7fff,   16'sh7fff);

    // Random: mostly near-unit axes, some anywhere, angles both small and full range
    for (int i = 0; i < N_RANDOM; i++) begin
      logic [31:0] a;
      logic [15:0] x, y, z;
      bit          hold;
      if ($urandom_range(2) == 0) begin
        a = $urandom;
      end else begin
        a = $urandom_range(47185920) - 32'd23592960;
      end
      if ($urandom_range(3) == 0) begin
        x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
      end else begin
        x = 16'($urandom_range(32768) - 32'd16384);
        y = 16'($urandom_range(32768) - 32'd16384);
        z = 16'($urandom_range(32768) - 32'd16384);
      end
      hold = (i == 400) || (i == 1000) || (i == 1600);
      add_req(a, x, y, z, hold);
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for all items to go in and all results to come out
    while (pending_reqs.size() > 0 || in_bus.valid) @(posedge clk_i);
    while (expected_mats.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
